/* rtl/ptb_pkg.sv */
package ptb_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;
  typedef enum logic [2:0] {
    K_ADDED = 3'd0,
    K_REMOVED = 3'd1,
    K_FIRED = 3'd2,
    K_SOONEST = 3'd3,
    K_ERROR = 3'd4
  } kind_t;
  localparam logic [31:0] ALL_ONES = 32'hffffffff;
endpackage

/* rtl/ptb_ram.sv */
module ptb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/periodic_timer_bank_unit.sv */
// channel  dir  tdata fields (low bit up)                tuser / tlast
// s_axis   in   op[1:0] period[33:2] slot[37:34] amount[69:38]  tuser=tag
// m_axis   out  kind[2:0] slot_out[6:3] soonest[38:7]     tuser=tag_out, tlast=last
// Add: a 33-step restoring divide for total mod period.
// Remove: one RAM read and copy per store. Advance: each live timer in turn
// is read, run through the shared serial divider and written back.
// Reset clears the timer count and elapsed total; table contents stay.
// A result waits in the output register; the sequencer halts only when its next result is ready while that one is held.
module periodic_timer_bank_unit
  import ptb_pkg::*;
#(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op, period, slot, amount, pad
  input  logic [7:0]  s_axis_tuser,   // tag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // kind, slot_out, soonest, pad
  output logic [7:0]  m_axis_tuser,   // tag_out
  output logic        m_axis_tlast    // last
);
  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RDREM, S_CPREM, S_RDADV, S_LDADV, S_DIV, S_ADDW,
    S_ADVW, S_NEXT, S_EMIT
  } state_t;

  state_t state;
  logic [1:0]    op;
  logic [31:0]   period, amount, total, soon;
  logic [7:0]    tag;
  logic [3:0]    slot_in;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic [32:0]   rem;
  logic [32:0]   quo;
  logic [31:0]   dvs;
  logic [5:0]    step;
  logic          due, is_add;
  logic [2:0]    res_kind;
  logic [3:0]    res_slot;
  logic [7:0]    res_tag;
  logic [31:0]   res_soon;
  logic          res_last;
  logic [2:0]    o_kind;
  logic [3:0]    o_slot;
  logic [7:0]    o_tag;
  logic [31:0]   o_soon;
  logic          o_last, o_valid;
  state_t        after_emit;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wper, wph, rper, rph;
  logic [7:0]    wtag, rtag;

  ptb_ram #(.WIDTH(32), .DEPTH(MAX_TIMERS)) u_per (
    .clk, .we, .waddr, .wdata(wper), .raddr, .rdata(rper));
  ptb_ram #(.WIDTH(32), .DEPTH(MAX_TIMERS)) u_ph (
    .clk, .we, .waddr, .wdata(wph), .raddr, .rdata(rph));
  ptb_ram #(.WIDTH(8), .DEPTH(MAX_TIMERS)) u_tag (
    .clk, .we, .waddr, .wdata(wtag), .raddr, .rdata(rtag));

  logic [33:0] trial;
  logic [32:0] rem_sh;
  logic [31:0] left;
  assign rem_sh = {rem[31:0], quo[32]};
  assign trial  = {1'b0, rem_sh} - {2'b0, dvs};
  assign left   = dvs - rem[31:0];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {1'b0, o_soon, o_slot, o_kind};
  assign m_axis_tuser  = o_tag;
  assign m_axis_tlast  = o_last;

  always_comb begin
    we = 1'b0;
    waddr = idx;
    raddr = idx;
    wper = period;
    wph = rem[31:0];
    wtag = tag;
    case (state)
      S_RDREM: raddr = AW'(count - CW'(1));
      S_CPREM: begin
        we = 1'b1; waddr = AW'(slot_in);
        wper = rper; wph = rph; wtag = rtag;
      end
      S_ADDW: begin we = 1'b1; waddr = count[AW-1:0]; end
      S_ADVW: begin we = 1'b1; wper = dvs; wtag = rtag; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && m_axis_tready && state != S_EMIT) o_valid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op <= s_axis_tdata[1:0];
          period <= s_axis_tdata[33:2];
          slot_in <= s_axis_tdata[37:34];
          amount <= s_axis_tdata[69:38];
          tag <= s_axis_tuser;
          state <= S_DECODE;
        end
        S_DECODE: begin
          res_kind <= K_ERROR; res_slot <= '0; res_tag <= '0; res_soon <= '0;
          res_last <= 1'b1; after_emit <= S_IDLE; state <= S_EMIT;
          case (op)
            OP_ADD: if (period != '0 && count < CW'(MAX_TIMERS)) begin
              is_add <= 1'b1; dvs <= period; rem <= '0;
              quo <= {1'b0, total}; step <= '0; state <= S_DIV;
            end
            OP_REMOVE: if (32'(slot_in) < 32'(count)) begin
              state <= S_RDREM;
            end
            OP_ADVANCE: begin
              total <= total + amount; soon <= ALL_ONES; idx <= '0;
              is_add <= 1'b0; state <= (count == '0) ? S_NEXT : S_RDADV;
            end
            default: ;
          endcase
        end
        S_RDREM: state <= S_CPREM;
        S_CPREM: begin
          count <= count - CW'(1);
          res_kind <= K_REMOVED; res_slot <= slot_in; state <= S_EMIT;
        end
        S_RDADV: state <= S_LDADV;
        S_LDADV: begin
          quo <= {1'b0, rph} + {1'b0, amount};
          due <= ({1'b0, rph} + {1'b0, amount}) >= {1'b0, rper};
          dvs <= rper; rem <= '0; step <= '0; state <= S_DIV;
        end
        S_DIV: begin
          if (!trial[33]) rem <= trial[32:0];
          else rem <= rem_sh;
          quo <= {quo[31:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'd32) state <= is_add ? S_ADDW : S_ADVW;
        end
        S_ADDW: begin
          count <= count + CW'(1);
          res_kind <= K_ADDED; res_slot <= 4'(count); state <= S_EMIT;
        end
        S_ADVW: begin
          if (left < soon) soon <= left;
          if (due) begin
            res_kind <= K_FIRED; res_slot <= 4'(idx); res_tag <= rtag;
            res_last <= 1'b0; after_emit <= S_NEXT; state <= S_EMIT;
          end else state <= S_NEXT;
        end
        S_NEXT: begin
          if (32'(idx) + 32'd1 < 32'(count) && count != '0) begin
            idx <= idx + AW'(1); state <= S_RDADV;
          end else begin
            res_kind <= K_SOONEST; res_slot <= '0; res_tag <= '0; res_soon <= soon;
            res_last <= 1'b1; after_emit <= S_IDLE; state <= S_EMIT;
          end
        end
        S_EMIT: if (!o_valid || m_axis_tready) begin
          o_kind <= res_kind; o_slot <= res_slot; o_tag <= res_tag;
          o_soon <= res_soon; o_last <= res_last;
          o_valid <= 1'b1; state <= after_emit;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TIMERS)) else $error("count overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("not busy");
endmodule

/* sim/testbench.sv */
module testbench;
  import ptb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NTIMERS = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 94;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] period;
    logic [7:0]  tag;
    logic [3:0]  slot;
    logic [31:0] amount;
  } cmd_t;

  typedef struct {
    kind_t       kind;
    logic [3:0]  slot;
    logic [7:0]  tag;
    logic [31:0] soon;
    logic        last;
  } evt_t;

  typedef struct {
    cmd_t        cmd;
    bit          typed;
    kind_t       kind;
    logic [31:0] soon;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // op, period, slot, amount, pad
  logic [7:0]  s_axis_tuser = '0;   // tag
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // kind, slot_out, soonest, pad
  logic [7:0]  m_axis_tuser;        // tag_out
  logic        m_axis_tlast;        // last

  periodic_timer_bank_unit u_top (.*);

  // timer table mirror
  logic [31:0] tbl_period [NTIMERS];
  logic [31:0] tbl_phase [NTIMERS];
  logic [7:0]  tbl_tag [NTIMERS];
  int          live = 0;
  logic [31:0] elapsed = '0;

  evt_t event_q[$];
  int   errors = 0;
  int   fired_seen = 0;
  int   err_seen = 0;
  int   words_in = 0;
  bit   calm = 1'b0;
  bit   hold_go = 1'b0;
  bit   done = 1'b0;
  int   hold_cnt = 0;
  int   quiet = 0;
  int   max_live = 0;

  initial forever #5 clk = ~clk;

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic evt_t mk(kind_t k, logic [3:0] s, logic [7:0] t, logic [31:0] so,
                              logic l);
    evt_t e;
    e.kind = k; e.slot = s; e.tag = t; e.soon = so; e.last = l;
    return e;
  endfunction

  task automatic predict_timers(cmd_t c);
    logic [32:0] sum;
    logic [31:0] left;
    logic [31:0] soon;
    soon = ALL_ONES;
    case (c.op)
      OP_ADD: begin
        if (c.period == 0 || live >= NTIMERS) begin
          event_q.push_back(mk(K_ERROR, 0, 0, 0, 1));
        end else begin
          tbl_period[live] = c.period;
          tbl_phase[live] = elapsed % c.period;
          tbl_tag[live] = c.tag;
          event_q.push_back(mk(K_ADDED, 4'(live), 0, 0, 1));
          live++;
        end
      end
      OP_REMOVE: begin
        if (c.slot >= live) begin
          event_q.push_back(mk(K_ERROR, 0, 0, 0, 1));
        end else begin
          tbl_period[c.slot] = tbl_period[live-1];
          tbl_phase[c.slot] = tbl_phase[live-1];
          tbl_tag[c.slot] = tbl_tag[live-1];
          live--;
          event_q.push_back(mk(K_REMOVED, c.slot, 0, 0, 1));
        end
      end
      OP_ADVANCE: begin
        elapsed = elapsed + c.amount;
        for (int i = 0; i < live; i++) begin
          sum = {1'b0, tbl_phase[i]} + {1'b0, c.amount};
          tbl_phase[i] = 32'(sum % {1'b0, tbl_period[i]});
          if (sum >= {1'b0, tbl_period[i]})
            event_q.push_back(mk(K_FIRED, 4'(i), tbl_tag[i], 0, 0));
          left = tbl_period[i] - tbl_phase[i];
          if (left < soon) soon = left;
        end
        event_q.push_back(mk(K_SOONEST, 0, 0, soon, 1));
      end
      default: event_q.push_back(mk(K_ERROR, 0, 0, 0, 1));
    endcase
    if (live > max_live) max_live = live;
  endtask

  task automatic send_word(cmd_t c, bit typed, kind_t k, logic [31:0] so);
    if (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, c.amount, c.slot, c.period, c.op};
    s_axis_tuser <= c.tag;
    do @(posedge clk); while (!s_axis_tready);
    words_in++;
    if (typed) begin
      predict_timers(c);
      void'(event_q.pop_back());
      event_q.push_back(mk(k, 0, 0, so, 1));
    end else begin
      predict_timers(c);
    end
  endtask

  function automatic cmd_t cm(logic [1:0] op, logic [31:0] p, logic [7:0] t,
                              logic [3:0] s, logic [31:0] a);
    cmd_t c;
    c.op = op; c.period = p; c.tag = t; c.slot = s; c.amount = a;
    return c;
  endfunction

  function automatic cmd_t random_cmd(bit fill);
    cmd_t c;
    int r;
    c = cm(2'($urandom_range(3)), $urandom, 8'($urandom_range(255)),
           4'($urandom_range(15)), $urandom);
    r = $urandom_range(99);
    if (fill || r < 40) begin
      c.op = OP_ADD;
      if ($urandom_range(9) < 8) c.period = $urandom_range(1, 200);
      else if ($urandom_range(9) == 0) c.period = 0;
    end else if (r < 75) begin
      c.op = OP_ADVANCE;
      if ($urandom_range(9) < 8) c.amount = $urandom_range(0, 300);
    end else if (r < 95) begin
      c.op = OP_REMOVE;
      if (live > 0 && $urandom_range(9) < 8) c.slot = 4'($urandom_range(live - 1));
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  row_t rows[$];

  initial begin
    cmd_t c;
    rows.push_back('{cm(OP_ADVANCE, 0, 0, 0, 32'd7), 1, K_SOONEST, ALL_ONES});
    rows.push_back('{cm(OP_ADD, 0, 8'h11, 0, 0), 1, K_ERROR, 0});
    rows.push_back('{cm(OP_REMOVE, 0, 0, 0, 0), 1, K_ERROR, 0});
    rows.push_back('{cm(OP_UNUSED, '1, 8'hff, 4'hf, '1), 1, K_ERROR, 0});
    rows.push_back('{cm(OP_ADD, 32'd1, 8'hff, 0, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADD, '1, 8'h00, 0, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADD, 32'd5, 8'ha5, 0, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADVANCE, 0, 0, 0, '1), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADVANCE, 0, 0, 0, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADVANCE, 0, 0, 0, 32'd3), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADD, 32'h8000_0001, 8'h5a, 0, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_ADVANCE, 0, 0, 0, 32'h8000_0000), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_REMOVE, 0, 0, 4'd3, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_REMOVE, 0, 0, 4'd0, 0), 0, K_ERROR, 0});
    rows.push_back('{cm(OP_REMOVE, 0, 0, 4'd5, 0), 1, K_ERROR, 0});
    rows.push_back('{cm(OP_ADVANCE, 0, 0, 0, 32'd12), 0, K_ERROR, 0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].kind, rows[i].soon);
    s_axis_tvalid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 60 && n < 85);
      if (n == 30) hold_go = 1'b1;
      c = random_cmd(n < 20 && live < NTIMERS + 1 && n < live + 4);
      send_word(c, 0, K_ERROR, 0);
    end
    s_axis_tvalid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    done = 1'b1;
    $display("Sent %0d words; %0d timer firings, %0d errors seen; table peaked at %0d.",
             words_in, fired_seen, err_seen, max_live);
    if (errors == 0 && event_q.size() == 0)
      $display("periodic_timer_bank_unit verification clean");
    else
      $display("periodic_timer_bank_unit verification failed");
    $finish;
  end

  always @(posedge clk) begin
    evt_t e;
    kind_t k;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        k = kind_t'(m_axis_tdata[2:0]);
        if (k == K_FIRED) fired_seen++;
        if (k == K_ERROR) err_seen++;
        if (event_q.size() == 0) begin
          report($sformatf("unexpected word %h", m_axis_tdata));
        end else begin
          e = event_q.pop_front();
          if (m_axis_tdata[2:0] !== e.kind || m_axis_tdata[6:3] !== e.slot ||
              m_axis_tuser !== e.tag || m_axis_tdata[38:7] !== e.soon ||
              m_axis_tlast !== e.last)
            report($sformatf("got k%0d s%0d t%h n%h l%b want k%0d s%0d t%h n%h l%b",
                   m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tuser,
                   m_axis_tdata[38:7], m_axis_tlast,
                   e.kind, e.slot, e.tag, e.soon, e.last));
        end
      end
      if (hold_go && hold_cnt == 0) begin
        hold_go <= 1'b0;
        hold_cnt <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= (hold_cnt == 1);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && !done) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", quiet);
        $display("periodic_timer_bank_unit verification failed");
        $finish;
      end
    end
  end
endmodule
